[src/bev_pkg.sv]
// ----------------------------------------------------------------------------
// bev_pkg
// Shared types and codes for the Bitap edit vector generator.
// ----------------------------------------------------------------------------
package bev_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDIT_THRESHOLD = 4'd1;

    localparam logic [6:0] PATTERN_LENGTH_RESET = 7'd64;
    localparam logic [4:0] EDIT_THRESHOLD_RESET = 5'd4;

    localparam logic signed [5:0] MIN_ERROR_NONE = -6'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_SCAN,
        ST_SCAN,
        ST_PREP_EMIT,
        ST_EMIT
    } bev_state_t;

    // sequencer to datapath
    typedef struct packed {
        logic s_ready;
        logic start_rd;
        logic scan_step;
        logic emit_step;
        logic last_level;
    } bev_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic found;
        logic out_free;
    } bev_stat_t;

endpackage

[src/bitap_edit_vector_generator.sv]
// ----------------------------------------------------------------------------
// bitap_edit_vector_generator
// Bit-parallel approximate matcher (k edits) producing traceback edit vectors.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: write pattern_length (index 0) and edit_threshold (index 1)
//   while the block is idle; cfg_ready is always high.
//   s_ channel: cmd 0 loads one pattern base into the base masks (first sets
//   all masks to ones beforehand); it gives no result.
//   cmd 1 feeds one text base, fed in reverse text order; first resets the
//   status vectors. Each text base gives k+1 transfers on the m_ channel,
//   levels 0..k in order, last_of_run on level k.
//   Timing: a read-ahead step, then one level per cycle (in emission, while
//   the result register is free) through the single level unit and the
//   status RAM read port; a new text base is taken only when idle. A final
//   text base first scans the levels for the least matching one, so
//   min_error is known on every one of its results.
//   A result register parts the channels: the next item is taken while the
//   last result waits. When the result register is full and m_ready is low the emit walk holds.
//   Reset clears the masks and status vectors to all ones and restores the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitap_edit_vector_generator
    import bev_pkg::*;
#(
    parameter int PATTERN_BITS = 64,
    parameter int MAX_ERRORS   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [2:0]                s_base,
    input  logic [15:0]               s_position,
    input  logic                      s_first,
    input  logic                      s_final_symbol,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [15:0]               m_text_index,
    output logic [4:0]                m_error_level,
    output logic [PATTERN_BITS-1:0]   m_match_vec,
    output logic [PATTERN_BITS-1:0]   m_subst_vec,
    output logic [PATTERN_BITS-1:0]   m_ins_vec,
    output logic [PATTERN_BITS-1:0]   m_del_vec,
    output logic                      m_last_of_run,
    output logic signed [5:0]         m_min_error
);

    localparam int PB    = PATTERN_BITS;
    localparam int DEPTH = MAX_ERRORS + 1;
    localparam int LW    = $clog2(DEPTH);
    localparam int IW    = $clog2(PB);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [6:0] pattern_length_reg;
    logic [4:0] edit_threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            edit_threshold_reg <= EDIT_THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[6:0];
                REG_EDIT_THRESHOLD: edit_threshold_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [6:0]    plen_m1;
    logic [IW-1:0] top_idx;
    logic [6:0]    m_eff;
    logic [LW+4:0] thr_ext;
    logic [LW-1:0] k_eff;

    always_comb begin
        plen_m1 = pattern_length_reg - 7'd1;
        if (pattern_length_reg == 7'd0) begin
            top_idx = '0;
        end else if (pattern_length_reg > 7'(PB)) begin
            top_idx = IW'(PB - 1);
        end else begin
            top_idx = plen_m1[IW-1:0];
        end
        m_eff = 7'(top_idx) + 7'd1;

        thr_ext = {{LW{1'b0}}, edit_threshold_reg};
        if (thr_ext > (LW+5)'(MAX_ERRORS)) begin
            k_eff = LW'(MAX_ERRORS);
        end else begin
            k_eff = thr_ext[LW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    bev_ctrl_t     ctrl;
    bev_stat_t     stat;
    logic [LW-1:0] level;

    bev_ctrl #(
        .MAX_ERRORS (MAX_ERRORS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_cmd          (s_cmd),
        .s_final_symbol (s_final_symbol),
        .k_eff          (k_eff),
        .stat           (stat),
        .ctrl           (ctrl),
        .level          (level)
    );

    assign s_ready = ctrl.s_ready;

    logic load_acc;
    logic text_acc;

    assign load_acc = s_valid && ctrl.s_ready && (s_cmd == CMD_LOAD);
    assign text_acc = s_valid && ctrl.s_ready && (s_cmd == CMD_TEXT);

    // ------------------------------------------------------------------
    // base masks
    // ------------------------------------------------------------------
    logic [PB-1:0] mask_reg [4];
    logic [IW-1:0] clr_idx;
    logic [PB-1:0] clr_vec;
    logic          clr_en;

    assign clr_idx = top_idx - s_position[IW-1:0];
    assign clr_vec = PB'(1) << clr_idx;
    assign clr_en  = !s_base[2] && (s_position < {9'd0, m_eff});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 4; j++) begin
                mask_reg[j] <= '1;
            end
        end else if (load_acc) begin
            for (int j = 0; j < 4; j++) begin
                mask_reg[j] <= (s_first ? {PB{1'b1}} : mask_reg[j])
                             & ~((clr_en && s_base[1:0] == 2'(j)) ? clr_vec : '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // per-item registers
    // ------------------------------------------------------------------
    logic [PB-1:0]      bm_reg;
    logic [15:0]        pos_reg;
    logic signed [5:0]  min_err_reg;
    logic [LW+5:0]      level_ext;

    assign level_ext = {6'd0, level};

    always_ff @(posedge aclk) begin
        if (text_acc) begin
            bm_reg      <= s_base[2] ? {PB{1'b1}} : mask_reg[s_base[1:0]];
            pos_reg     <= s_position;
            min_err_reg <= s_final_symbol ? MIN_ERROR_NONE : 6'sd0;
        end else if (ctrl.scan_step && stat.found) begin
            min_err_reg <= level_ext[5:0];
        end
    end

    // ------------------------------------------------------------------
    // status vector store: invalid entries read as all ones
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] stat_vld_reg;
    logic             rd_vld_reg;
    logic             rd_en;
    logic [LW-1:0]    rd_addr;
    logic [PB-1:0]    rd_data;
    logic [PB-1:0]    old_vec;
    logic [PB-1:0]    new_vec;

    assign rd_en   = ctrl.start_rd
                   || ((ctrl.scan_step || ctrl.emit_step) && !ctrl.last_level);
    assign rd_addr = ctrl.start_rd ? '0 : level + LW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_vld_reg <= '0;
        end else if (text_acc && s_first) begin
            stat_vld_reg <= '0;
        end else if (ctrl.emit_step) begin
            stat_vld_reg[level] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_reg <= stat_vld_reg[rd_addr];
        end
    end

    bev_ram #(
        .WIDTH (PB),
        .DEPTH (DEPTH)
    ) u_status_ram (
        .aclk    (aclk),
        .wr_en   (ctrl.emit_step),
        .wr_addr (level),
        .wr_data (new_vec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign old_vec = rd_vld_reg ? rd_data : {PB{1'b1}};

    // ------------------------------------------------------------------
    // level unit
    // ------------------------------------------------------------------
    logic [PB-1:0] prev_old_reg;
    logic [PB-1:0] prev_new_reg;
    logic [PB-1:0] match_vec;
    logic [PB-1:0] subst_vec;
    logic [PB-1:0] ins_vec;
    logic [PB-1:0] del_vec;
    logic [PB-1:0] top_mask;

    bev_level_unit #(
        .W (PB)
    ) u_level (
        .level0       (level == '0),
        .old_vec      (old_vec),
        .prev_old_vec (prev_old_reg),
        .prev_new_vec (prev_new_reg),
        .base_mask    (bm_reg),
        .match_vec    (match_vec),
        .subst_vec    (subst_vec),
        .ins_vec      (ins_vec),
        .del_vec      (del_vec),
        .new_vec      (new_vec)
    );

    // carry the level below into the next step
    always_ff @(posedge aclk) begin
        if (ctrl.scan_step || ctrl.emit_step) begin
            prev_old_reg <= old_vec;
            prev_new_reg <= new_vec;
        end
    end

    assign top_mask   = PB'(1) << top_idx;
    assign stat.found = ((new_vec & top_mask) == '0);

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic out_valid_reg;

    assign stat.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.emit_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit_step) begin
            m_text_index  <= pos_reg;
            m_error_level <= level_ext[4:0];
            m_match_vec   <= match_vec;
            m_subst_vec   <= subst_vec;
            m_ins_vec     <= ins_vec;
            m_del_vec     <= del_vec;
            m_last_of_run <= ctrl.last_level;
            m_min_error   <= min_err_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

[src/bev_ram.sv]
// ----------------------------------------------------------------------------
// bev_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bev_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 17
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/bev_level_unit.sv]
// ----------------------------------------------------------------------------
// bev_level_unit
// Shared edit-level update: builds the four edit vectors and the new status
// vector of one error level from the old vector and the level below.
// ----------------------------------------------------------------------------
module bev_level_unit #(
    parameter int W = 64
) (
    input  logic         level0,
    input  logic [W-1:0] old_vec,
    input  logic [W-1:0] prev_old_vec,
    input  logic [W-1:0] prev_new_vec,
    input  logic [W-1:0] base_mask,
    output logic [W-1:0] match_vec,
    output logic [W-1:0] subst_vec,
    output logic [W-1:0] ins_vec,
    output logic [W-1:0] del_vec,
    output logic [W-1:0] new_vec
);

    always_comb begin
        match_vec = {old_vec[W-2:0], 1'b0} | base_mask;
        if (level0) begin
            subst_vec = '1;
            ins_vec   = '1;
            del_vec   = '1;
            new_vec   = match_vec;
        end else begin
            del_vec   = prev_old_vec;
            subst_vec = {prev_old_vec[W-2:0], 1'b0};
            ins_vec   = {prev_new_vec[W-2:0], 1'b0};
            new_vec   = del_vec & subst_vec & ins_vec & match_vec;
        end
    end

endmodule

[src/bev_ctrl.sv]
// ----------------------------------------------------------------------------
// bev_ctrl
// Level sequencer: walks error levels up from 0 to the least matching level
// (final text base only, at most k), then 0..k to emit and commit results.
// ----------------------------------------------------------------------------
module bev_ctrl
    import bev_pkg::*;
#(
    parameter int MAX_ERRORS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_cmd,
    input  logic                            s_final_symbol,
    input  logic [$clog2(MAX_ERRORS+1)-1:0] k_eff,
    input  bev_stat_t                       stat,
    output bev_ctrl_t                       ctrl,
    output logic [$clog2(MAX_ERRORS+1)-1:0] level
);

    localparam int LW = $clog2(MAX_ERRORS + 1);

    bev_state_t    state_reg, state_next;
    logic [LW-1:0] level_reg, level_next;
    logic          last_level;

    assign last_level = (level_reg == k_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        case (state_reg)
            ST_IDLE: begin
                level_next = '0;
                if (s_valid && s_cmd == CMD_TEXT) begin
                    state_next = s_final_symbol ? ST_PREP_SCAN : ST_PREP_EMIT;
                end
            end
            ST_PREP_SCAN: begin
                level_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.found || last_level) begin
                    state_next = ST_PREP_EMIT;
                end else begin
                    level_next = level_reg + LW'(1);
                end
            end
            ST_PREP_EMIT: begin
                level_next = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    if (last_level) begin
                        state_next = ST_IDLE;
                    end else begin
                        level_next = level_reg + LW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                level_next = '0;
            end
        endcase
    end

    always_comb begin
        ctrl            = '0;
        ctrl.last_level = last_level;
        case (state_reg)
            ST_IDLE:      ctrl.s_ready   = 1'b1;
            ST_PREP_SCAN: ctrl.start_rd  = 1'b1;
            ST_PREP_EMIT: ctrl.start_rd  = 1'b1;
            ST_SCAN:      ctrl.scan_step = 1'b1;
            ST_EMIT:      ctrl.emit_step = stat.out_free;
            default:      ctrl.s_ready   = 1'b0;
        endcase
    end

    assign level = level_reg;

endmodule
